[design/crs_pkg.sv]
// Shared types and constants of the cartesian rank and shift unit.
`default_nettype none

package crs_pkg;

  localparam int unsigned MaxDims  = 4;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned NdW      = 3;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned RankW    = 32;
  localparam int unsigned ExtW     = 9;
  localparam int unsigned PosW     = 8;
  localparam int unsigned StrideW  = 25;
  localparam int unsigned NodesW   = 33;
  localparam int unsigned NumSteps = 16;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    OpToRank   = 2'd0,
    OpToCoords = 2'd1,
    OpShift    = 2'd2,
    OpBad      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadArg = 2'd1,
    StBadDim = 2'd2
  } st_e;

  typedef enum logic [RegIdxW-1:0] {
    RegNumDims = 3'd0,
    RegSizeA   = 3'd1,
    RegSizeB   = 3'd2,
    RegSizeC   = 3'd3,
    RegSizeD   = 3'd4,
    RegWrap    = 3'd5,
    RegOwnRank = 3'd6
  } reg_e;

  typedef struct packed {
    logic                               busy;
    logic [NdW-1:0]                     nd;
    logic [NumLanes-1:0][ExtW-1:0]      ext;
    logic [NumLanes-1:0]                wrap;
    logic [RankW-1:0]                   own_rank;
    logic [NumLanes-1:0][StrideW-1:0]   stride;
    logic [NodesW-1:0]                  nodes;
    logic [NumLanes-1:0][PosW-1:0]      own_pos;
    logic                               own_bad;
  } cfg_t;

  typedef struct packed {
    op_e                                op;
    st_e                                status;
    logic                               dnull;
    logic                               snull;
    logic [1:0]                         dir;
    logic [NumLanes-1:0]                neg;
    logic [NumLanes-1:0][CoordW-1:0]    mag;
    logic [NumLanes-1:0][ExtW-1:0]      div;
    logic [RankW-1:0]                   rank;
  } req_t;

  typedef struct packed {
    op_e                                op;
    st_e                                status;
    logic                               dnull;
    logic                               snull;
    logic [1:0]                         dir;
    logic [NumLanes-1:0]                neg;
    logic [NumLanes-1:0][CoordW-1:0]    mag;
    logic [NumLanes-1:0][ExtW-1:0]      div;
    logic [NumLanes-1:0][ExtW-1:0]      rem;
    logic [RankW-1:0]                   srem;
    logic [NumLanes-1:0][PosW-1:0]      quo;
  } pipe_t;

  typedef struct packed {
    logic [RankW-1:0]                   rank_out;
    logic [NumLanes-1:0][PosW-1:0]      coord;
    logic [RankW-1:0]                   dest_rank;
    logic [RankW-1:0]                   source_rank;
    logic                               dest_null;
    logic                               source_null;
    st_e                                status;
  } res_t;

endpackage

`default_nettype wire

[design/crs_fifo.sv]
// Small synchronous queue used between the stages of the unit.
`default_nettype none

module crs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  // Depth must be at least two.
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[design/crs_cfg.sv]
// Configuration registers and the sequencer that derives strides and own coordinates.
`default_nettype none

module crs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crs_pkg::RegIdxW-1:0]    cfg_idx_i,
  input  logic [crs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output crs_pkg::cfg_t                  cfg_o
);

  import crs_pkg::*;

  localparam int unsigned SeqW = 6;
  localparam logic [SeqW-1:0] SeqStrideB  = SeqW'(0);
  localparam logic [SeqW-1:0] SeqStrideA  = SeqW'(1);
  localparam logic [SeqW-1:0] SeqNodes    = SeqW'(2);
  localparam logic [SeqW-1:0] SeqDivFirst = SeqW'(3);
  localparam logic [SeqW-1:0] SeqDone     = SeqW'(3 + RankW);

  logic [NdW-1:0]                   nd_raw_q;
  logic [NumLanes-1:0][ExtW-1:0]    size_q;
  logic [NumLanes-1:0]              wrap_q;
  logic [RankW-1:0]                 own_q;
  logic [SeqW-1:0]                  cnt_q;
  logic [StrideW-1:0]               s1_q, s0_q;
  logic [NodesW-1:0]                nodes_q;
  logic [RankW-1:0]                 rem_q, rem_d;
  logic [NumLanes-1:0][PosW-1:0]    pos_q;
  logic                             own_bad_q;

  logic [NumLanes-1:0][ExtW-1:0]    ext, eu;
  logic [NdW-1:0]                   nd;
  logic [NumLanes-1:0][StrideW-1:0] stride;
  logic [4:0]                       k;
  logic [1:0]                       kdim;
  logic [2:0]                       kbit;
  logic [NodesW-1:0]                cmp;
  logic                             ge;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      if (size_q[i] == '0) begin
        ext[i] = ExtW'(1);
      end else if (size_q[i] > ExtW'(256)) begin
        ext[i] = ExtW'(256);
      end else begin
        ext[i] = size_q[i];
      end
      eu[i] = (NdW'(i) < nd) ? ext[i] : ExtW'(1);
    end
  end

  assign nd = (nd_raw_q > NdW'(MaxDims)) ? NdW'(MaxDims) : nd_raw_q;

  assign stride[0] = s0_q;
  assign stride[1] = s1_q;
  assign stride[2] = StrideW'(eu[3]);
  assign stride[3] = StrideW'(1);

  // One quotient bit of the own rank per cycle, most significant dimension first.
  assign k     = 5'(cnt_q - SeqDivFirst);
  assign kdim  = k[4:3];
  assign kbit  = 3'd7 - k[2:0];
  assign cmp   = NodesW'(stride[kdim]) << kbit;
  assign ge    = ({1'b0, rem_q} >= cmp);
  assign rem_d = ge ? RankW'({1'b0, rem_q} - cmp) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_raw_q  <= NdW'(1);
      size_q    <= {NumLanes{ExtW'(1)}};
      wrap_q    <= '0;
      own_q     <= '0;
      cnt_q     <= SeqDone;
      s1_q      <= StrideW'(1);
      s0_q      <= StrideW'(1);
      nodes_q   <= NodesW'(1);
      rem_q     <= '0;
      pos_q     <= '0;
      own_bad_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          RegNumDims: nd_raw_q  <= cfg_wdata_i[NdW-1:0];
          RegSizeA:   size_q[0] <= cfg_wdata_i[ExtW-1:0];
          RegSizeB:   size_q[1] <= cfg_wdata_i[ExtW-1:0];
          RegSizeC:   size_q[2] <= cfg_wdata_i[ExtW-1:0];
          RegSizeD:   size_q[3] <= cfg_wdata_i[ExtW-1:0];
          RegWrap:    wrap_q    <= cfg_wdata_i[NumLanes-1:0];
          RegOwnRank: own_q     <= cfg_wdata_i[RankW-1:0];
          default: ;
        endcase
        cnt_q <= SeqStrideB;
      end else if (cnt_q != SeqDone) begin
        cnt_q <= cnt_q + 1'b1;
      end

      if (cnt_q == SeqStrideB) begin
        s1_q <= StrideW'(eu[2] * eu[3]);
      end
      if (cnt_q == SeqStrideA) begin
        s0_q <= StrideW'(eu[1] * s1_q);
      end
      if (cnt_q == SeqNodes) begin
        nodes_q <= NodesW'(eu[0] * s0_q);
        rem_q   <= own_q;
        pos_q   <= '0;
      end
      if (cnt_q == SeqDivFirst) begin
        own_bad_q <= ({1'b0, own_q} >= nodes_q);
      end
      if (cnt_q >= SeqDivFirst && cnt_q != SeqDone) begin
        rem_q              <= rem_d;
        pos_q[kdim][kbit]  <= ge;
      end
    end
  end

  always_comb begin
    cfg_o          = '0;
    cfg_o.busy     = (cnt_q != SeqDone);
    cfg_o.nd       = nd;
    cfg_o.ext      = ext;
    cfg_o.wrap     = wrap_q;
    cfg_o.own_rank = own_q;
    cfg_o.stride   = stride;
    cfg_o.nodes    = nodes_q;
    cfg_o.own_pos  = pos_q;
    cfg_o.own_bad  = own_bad_q;
  end

endmodule

`default_nettype wire

[design/crs_front.sv]
// Front end: checks and classifies a request and prepares the divider lanes.
`default_nettype none

module crs_front (
  input  crs_pkg::cfg_t                 cfg_i,
  input  logic [1:0]                    operation_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_a_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_b_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_c_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_d_i,
  input  logic [crs_pkg::RankW-1:0]     query_rank_i,
  input  logic [2:0]                    direction_i,
  input  logic [crs_pkg::CoordW-1:0]    displacement_i,
  output crs_pkg::req_t                 req_o
);

  import crs_pkg::*;

  logic [NumLanes-1:0][CoordW-1:0] coord;

  assign coord[0] = coord_a_i;
  assign coord[1] = coord_b_i;
  assign coord[2] = coord_c_i;
  assign coord[3] = coord_d_i;

  always_comb begin
    logic               bad;
    logic               oor;
    logic signed [CoordW:0] xd, xs, ext_s;
    logic [1:0]         d;
    req_o     = '0;
    bad       = 1'b0;
    oor       = 1'b0;
    d         = direction_i[1:0];
    ext_s     = $signed({{(CoordW + 1 - ExtW){1'b0}}, cfg_i.ext[d]});
    xd        = $signed({{(CoordW + 1 - PosW){1'b0}}, cfg_i.own_pos[d]})
              + $signed({displacement_i[CoordW-1], displacement_i});
    xs        = $signed({{(CoordW + 1 - PosW){1'b0}}, cfg_i.own_pos[d]})
              - $signed({displacement_i[CoordW-1], displacement_i});
    req_o.op  = op_e'(operation_i);
    req_o.dir = d;
    for (int i = 0; i < NumLanes; i++) begin
      req_o.div[i] = ExtW'(1);
    end
    unique case (op_e'(operation_i))
      OpToRank: begin
        for (int i = 0; i < NumLanes; i++) begin
          if (NdW'(i) < cfg_i.nd) begin
            oor = coord[i][CoordW-1] ||
                  ({1'b0, coord[i]} >= (CoordW + 1)'(cfg_i.ext[i]));
            if (oor && !cfg_i.wrap[i]) begin
              bad = 1'b1;
            end
            req_o.neg[i] = coord[i][CoordW-1];
            req_o.mag[i] = coord[i][CoordW-1] ? CoordW'(-coord[i]) : coord[i];
            req_o.div[i] = cfg_i.ext[i];
          end
        end
        req_o.status = bad ? StBadArg : StOk;
      end
      OpToCoords: begin
        req_o.rank   = query_rank_i;
        req_o.status = ({1'b0, query_rank_i} >= cfg_i.nodes) ? StBadArg : StOk;
      end
      OpShift: begin
        priority if (cfg_i.nd == '0) begin
          req_o.status = StBadArg;
        end else if (direction_i >= cfg_i.nd) begin
          req_o.status = StBadDim;
        end else if (cfg_i.own_bad) begin
          req_o.status = StBadArg;
        end else begin
          req_o.status = StOk;
          req_o.dnull  = ((xd < 0) || (xd >= ext_s)) && !cfg_i.wrap[d];
          req_o.snull  = ((xs < 0) || (xs >= ext_s)) && !cfg_i.wrap[d];
          req_o.neg[0] = xd[CoordW];
          req_o.neg[1] = xs[CoordW];
          req_o.mag[0] = xd[CoordW] ? CoordW'(-xd) : xd[CoordW-1:0];
          req_o.mag[1] = xs[CoordW] ? CoordW'(-xs) : xs[CoordW-1:0];
          req_o.div[0] = cfg_i.ext[d];
          req_o.div[1] = cfg_i.ext[d];
        end
      end
      OpBad: begin
        req_o.status = StBadArg;
      end
      default: begin
        req_o.status = StBadArg;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/crs_back.sv]
// Back end: pipelined remainder lanes, rank splitter and rank assembly.
`default_nettype none

module crs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crs_pkg::cfg_t  cfg_i,
  input  crs_pkg::req_t  req_i,
  input  logic           req_empty_i,
  output logic           req_pop_o,
  output crs_pkg::res_t  res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);

  import crs_pkg::*;

  logic                          en;
  pipe_t                         ent;
  pipe_t                         step_d [NumSteps];
  pipe_t                         pipe_q [NumSteps];
  logic [NumSteps-1:0]           vld_q;
  pipe_t                         fix_d, fix_q, prd_q;
  logic                          fix_vld_q, prd_vld_q;
  logic [NumLanes-1:0][RankW-1:0] prod_d, prod_q;

  // The whole pipeline moves together; it stalls only on a full result queue.
  assign en         = ~res_full_i;
  assign req_pop_o  = en & ~req_empty_i;
  assign res_push_o = en & prd_vld_q;

  always_comb begin
    ent        = '0;
    ent.op     = req_i.op;
    ent.status = req_i.status;
    ent.dnull  = req_i.dnull;
    ent.snull  = req_i.snull;
    ent.dir    = req_i.dir;
    ent.neg    = req_i.neg;
    ent.mag    = req_i.mag;
    ent.div    = req_i.div;
    ent.srem   = req_i.rank;
  end

  for (genvar g = 0; g < NumSteps; g++) begin : g_step
    localparam int unsigned Dim = (2 * g) / 8;
    localparam int unsigned B0  = 7 - ((2 * g) % 8);
    localparam int unsigned B1  = B0 - 1;
    pipe_t src;

    if (g == 0) begin : g_first
      assign src = ent;
    end else begin : g_next
      assign src = pipe_q[g-1];
    end

    always_comb begin
      logic [ExtW:0]     t;
      logic [NodesW-1:0] c0, c1;
      logic [RankW-1:0]  r;
      step_d[g] = src;
      // One remainder bit per lane.
      for (int i = 0; i < NumLanes; i++) begin
        t = {src.rem[i], src.mag[i][CoordW-1-g]};
        if (t >= {1'b0, src.div[i]}) begin
          step_d[g].rem[i] = ExtW'(t - {1'b0, src.div[i]});
        end else begin
          step_d[g].rem[i] = t[ExtW-1:0];
        end
      end
      // Two quotient bits of the rank against the stride of one dimension.
      c0 = NodesW'(cfg_i.stride[Dim]) << B0;
      c1 = NodesW'(cfg_i.stride[Dim]) << B1;
      r  = src.srem;
      if ({1'b0, r} >= c0) begin
        r = RankW'({1'b0, r} - c0);
        step_d[g].quo[Dim][B0] = 1'b1;
      end
      if ({1'b0, r} >= c1) begin
        r = RankW'({1'b0, r} - c1);
        step_d[g].quo[Dim][B1] = 1'b1;
      end
      step_d[g].srem = r;
    end
  end

  // Floor modulo: a negative value with a nonzero remainder folds up from the divisor.
  always_comb begin
    fix_d = pipe_q[NumSteps-1];
    for (int i = 0; i < NumLanes; i++) begin
      if (fix_d.neg[i] && fix_d.rem[i] != '0) begin
        fix_d.rem[i] = fix_d.div[i] - fix_d.rem[i];
      end
    end
  end

  always_comb begin
    logic [ExtW+StrideW-1:0] p;
    logic [StrideW-1:0]      sd;
    sd = cfg_i.stride[fix_q.dir];
    for (int i = 0; i < NumLanes; i++) begin
      if (fix_q.op == OpShift) begin
        if (i == 2) begin
          p = {1'b0, cfg_i.own_pos[fix_q.dir]} * sd;
        end else begin
          p = fix_q.rem[i] * sd;
        end
      end else begin
        p = fix_q.rem[i] * cfg_i.stride[i];
      end
      prod_d[i] = p[RankW-1:0];
    end
  end

  always_comb begin
    logic [RankW-1:0] base;
    base  = cfg_i.own_rank - prod_q[2];
    res_o = '0;
    res_o.status = prd_q.status;
    if (prd_q.status == StOk) begin
      unique case (prd_q.op)
        OpToRank: begin
          res_o.rank_out = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3];
        end
        OpToCoords: begin
          res_o.coord = prd_q.quo;
        end
        OpShift: begin
          res_o.dest_null   = prd_q.dnull;
          res_o.source_null = prd_q.snull;
          res_o.dest_rank   = prd_q.dnull ? '0 : base + prod_q[0];
          res_o.source_rank = prd_q.snull ? '0 : base + prod_q[1];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fix_vld_q <= 1'b0;
      prd_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NumSteps-2:0], ~req_empty_i};
      fix_vld_q <= vld_q[NumSteps-1];
      prd_vld_q <= fix_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NumSteps; s++) begin
        pipe_q[s] <= step_d[s];
      end
      fix_q  <= fix_d;
      prd_q  <= fix_q;
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

[design/cartesian_rank_and_shift_unit.sv]
// Top level of the cartesian rank and shift unit.
`default_nettype none

// Converts between signed grid coordinates and row-major ranks on a grid of up
// to four dimensions, splits ranks back into coordinates and finds the two
// neighbours of the own position along one direction. The unit takes one
// request per clock cycle while full is low and returns one result per
// request, in order. A request passes the queue in front of the back end and
// then the back end (sixteen pipelined remainder and quotient steps, one
// floor-modulo fixup and one multiply stage) before its result enters the
// result queue and shows on the outputs. After any register write the unit
// holds full high while its sequencer forms the dimension strides and the
// node count by three multiplications and then derives the own coordinates
// one quotient bit per cycle; the write port itself never waits. Registers
// are meant to be written only while no request is in flight.

module cartesian_rank_and_shift_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crs_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [crs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    operation_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_a_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_b_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_c_i,
  input  logic [crs_pkg::CoordW-1:0]    coord_d_i,
  input  logic [crs_pkg::RankW-1:0]     query_rank_i,
  input  logic [2:0]                    direction_i,
  input  logic [crs_pkg::CoordW-1:0]    displacement_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [crs_pkg::RankW-1:0]     rank_out_o,
  output logic [crs_pkg::PosW-1:0]      out_coord_a_o,
  output logic [crs_pkg::PosW-1:0]      out_coord_b_o,
  output logic [crs_pkg::PosW-1:0]      out_coord_c_o,
  output logic [crs_pkg::PosW-1:0]      out_coord_d_o,
  output logic [crs_pkg::RankW-1:0]     dest_rank_o,
  output logic [crs_pkg::RankW-1:0]     source_rank_o,
  output logic                          dest_null_o,
  output logic                          source_null_o,
  output logic [1:0]                    status_o
);

  import crs_pkg::*;

  localparam int unsigned ReqW = $bits(req_t);
  localparam int unsigned ResW = $bits(res_t);

  cfg_t            cfg;
  req_t            req_new, req_head;
  logic [ReqW-1:0] req_head_bits;
  logic            mid_full, mid_empty, mid_pop, mid_push;
  res_t            res_new, res_head;
  logic [ResW-1:0] res_head_bits;
  logic            res_push, res_full;

  crs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The front end checks each request against the grid and forms the divider
  // operands; a request is taken whenever the queue to the back end has room and the sequencer is not busy.
  crs_front u_front (
    .cfg_i          (cfg),
    .operation_i    (operation_i),
    .coord_a_i      (coord_a_i),
    .coord_b_i      (coord_b_i),
    .coord_c_i      (coord_c_i),
    .coord_d_i      (coord_d_i),
    .query_rank_i   (query_rank_i),
    .direction_i    (direction_i),
    .displacement_i (displacement_i),
    .req_o          (req_new)
  );

  assign full     = cfg.busy | mid_full;
  assign mid_push = push & ~full;

  crs_fifo #(
    .Width (ReqW),
    .Depth (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (req_new),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (req_head_bits),
    .empty_o (mid_empty)
  );

  assign req_head = req_t'(req_head_bits);

  crs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_head),
    .req_empty_i (mid_empty),
    .req_pop_o   (mid_pop),
    .res_o       (res_new),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // The result queue decouples the consumer: a waiting result never blocks
  // the back end as long as one slot is free.
  crs_fifo #(
    .Width (ResW),
    .Depth (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_new),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head_bits),
    .empty_o (empty)
  );

  assign res_head      = res_t'(res_head_bits);
  assign rank_out_o    = res_head.rank_out;
  assign out_coord_a_o = res_head.coord[0];
  assign out_coord_b_o = res_head.coord[1];
  assign out_coord_c_o = res_head.coord[2];
  assign out_coord_d_o = res_head.coord[3];
  assign dest_rank_o   = res_head.dest_rank;
  assign source_rank_o = res_head.source_rank;
  assign dest_null_o   = res_head.dest_null;
  assign source_null_o = res_head.source_null;
  assign status_o      = res_head.status;

endmodule

`default_nettype wire

[design/crs_checker.sv]
// Port-level checker of the cartesian rank and shift unit and its bind.
`default_nettype none

module crs_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [crs_pkg::RankW-1:0]     rank_out_o,
  input logic [crs_pkg::PosW-1:0]      out_coord_a_o,
  input logic [crs_pkg::PosW-1:0]      out_coord_b_o,
  input logic [crs_pkg::PosW-1:0]      out_coord_c_o,
  input logic [crs_pkg::PosW-1:0]      out_coord_d_o,
  input logic [crs_pkg::RankW-1:0]     dest_rank_o,
  input logic [crs_pkg::RankW-1:0]     source_rank_o,
  input logic                          dest_null_o,
  input logic                          source_null_o,
  input logic [1:0]                    status_o
);

  import crs_pkg::*;

  // A register write always starts the recompute, which blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> full)
    else $error("no recompute after a register write");

  // A failed request carries nothing but its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != StOk) |->
      (rank_out_o == '0 && dest_rank_o == '0 && source_rank_o == '0 &&
       !dest_null_o && !source_null_o && out_coord_a_o == '0 &&
       out_coord_b_o == '0 && out_coord_c_o == '0 && out_coord_d_o == '0))
    else $error("fields set on a failed request");

  // A missing neighbour has rank zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (dest_null_o || source_null_o)) |->
      ((!dest_null_o || dest_rank_o == '0) &&
       (!source_null_o || source_rank_o == '0)))
    else $error("null neighbour with a nonzero rank");

  // A result that is not taken stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(rank_out_o)))
    else $error("waiting result changed");

endmodule

bind cartesian_rank_and_shift_unit crs_port_checker u_crs_checker (.*);

`default_nettype wire
